/* hw/rtl/dpl_pkg.sv */
// Shared types and constants for the decimal pre-period length block.
// Used by the controller, the datapath, the divider and the top level.
package dpl_pkg;

    // Default operand width of the numerator and denominator.
    localparam int VALUE_WIDTH_DEF = 31;

    // Width and ceiling of the reported pre-period length.
    localparam int LEN_WIDTH = 5;
    localparam int LEN_MAX   = 31;

    // The odd factor of ten that is stripped by exact division.
    localparam int FACTOR_FIVE = 5;

    // Which operation the shared divider performs.
    typedef enum logic [1:0] {
        OP_MODX = 2'd0,   // x = x mod y
        OP_MODY = 2'd1,   // y = y mod x
        OP_RED  = 2'd2    // red = den / gcd
    } t_div_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_step;
        logic    wb;
        logic    five_start;
        logic    five_step;
        logic    five_wb;
        logic    shift2;
        logic    out_load;
        t_div_op div_op;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic den_zero;
        logic x_zero;
        logic y_zero;
        logic x_gt_y;
        logic div_last;
        logic five_last;
        logic five_hit;
        logic red_even;
    } t_status;

endpackage

/* hw/rtl/dpl_divider.sv */
// Restoring divider that retires one quotient bit per cycle while i_step is high.
// Shared by the Euclid and reduction steps; takes its default width from dpl_pkg.
module dpl_divider #(
    parameter int W = dpl_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_step,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder,
    output logic         o_last
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;

    logic [W:0]   w_partial;
    logic [W:0]   w_diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_partial = {r_rem, r_quo[W-1]};
    assign w_diff    = w_partial - {1'b0, r_div};

    // Operand and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (i_step) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
            end else begin
                r_rem <= w_partial[W-1:0];
            end
            r_quo <= {r_quo[W-2:0], ~w_diff[W]};
        end
    end

    // Bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(W);
        end else if (i_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_last      = (r_cnt == CNT_W'(1));

`ifndef SYNTH
    a_div_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (r_div != '0))
        else $error("divider stepped with a zero divisor");

    a_step_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (r_cnt != '0))
        else $error("divider stepped past its last bit");

    a_rem_below_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_last) |=> (r_rem < r_div))
        else $error("final remainder not below divisor");
`endif

endmodule

/* hw/rtl/dpl_datapath.sv */
// Datapath: Euclid operands, reduced denominator, factor counters and output register.
// Depends on dpl_pkg and instantiates dpl_divider.
module dpl_datapath #(
    parameter int W = dpl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dpl_pkg::t_cmd              i_cmd,
    output dpl_pkg::t_status           o_status,
    input  logic [W-1:0]               i_numerator,
    input  logic [W-1:0]               i_denominator,
    output logic [W-1:0]               o_stripped_denominator,
    output logic [dpl_pkg::LEN_WIDTH-1:0] o_preperiod_length
);
    import dpl_pkg::*;

    localparam int CW = $clog2(W + 1);
    localparam int LW = (CW > LEN_WIDTH) ? CW : LEN_WIDTH;

    // Exact division by five: a multiple of five times the inverse of five
    // modulo 2^W lands at or below this limit, any other value lands above it.
    localparam logic [W-1:0] ALL_ONES   = '1;
    localparam logic [W-1:0] FIVE_LIMIT = ALL_ONES / W'(FACTOR_FIVE);
    localparam logic [2:0]   PH_TIMES3  = 3'd4;
    localparam logic [2:0]   PH_NEGATE  = 3'd5;

    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_red;
    logic [W-1:0]  r_f;
    logic [2:0]    r_fph;
    logic [CW-1:0] r_c5;
    logic [CW-1:0] r_c2;
    logic [W-1:0]  r_out_den;
    logic [LEN_WIDTH-1:0] r_out_len;

    logic [W-1:0]  w_dividend;
    logic [W-1:0]  w_divisor;
    logic [W-1:0]  w_quo;
    logic [W-1:0]  w_rem;
    logic          w_last;
    logic [W-1:0]  w_gcd;
    logic [5:0]    w_fsh;
    logic          w_five_hit;
    logic [CW-1:0] w_cmax;
    logic [LW-1:0] w_len_ext;
    logic [LEN_WIDTH-1:0] w_len;

    // The gcd is the larger operand once the other one reaches zero.
    assign w_gcd = (r_x > r_y) ? r_x : r_y;

    // Divider operand selection.
    always_comb begin
        case (i_cmd.div_op)
            OP_MODX: begin
                w_dividend = r_x;
                w_divisor  = r_y;
            end
            OP_MODY: begin
                w_dividend = r_y;
                w_divisor  = r_x;
            end
            OP_RED: begin
                w_dividend = r_den;
                w_divisor  = w_gcd;
            end
            default: begin
                w_dividend = r_x;
                w_divisor  = r_y;
            end
        endcase
    end

    dpl_divider #(
        .W (W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_step      (i_cmd.div_step),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_last      (w_last)
    );

    // Euclid operands and the saved denominator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_numerator;
            r_y   <= i_denominator;
            r_den <= i_denominator;
        end else if (i_cmd.wb && (i_cmd.div_op == OP_MODX)) begin
            r_x <= w_rem;
        end else if (i_cmd.wb && (i_cmd.div_op == OP_MODY)) begin
            r_y <= w_rem;
        end
    end

    // Multiply the reduced denominator by the inverse of five modulo 2^W in six
    // steps: four shift-and-add steps build x * 0x1111..., then it is tripled
    // and negated, which gives x * 0xCCCC...CD.
    assign w_fsh = 6'd4 << r_fph[1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.five_start) begin
            r_f   <= r_red;
            r_fph <= '0;
        end else if (i_cmd.five_step) begin
            if (r_fph == PH_NEGATE) begin
                r_f <= '0 - r_f;
            end else if (r_fph == PH_TIMES3) begin
                r_f <= r_f + (r_f << 1);
            end else begin
                r_f <= r_f + (r_f << w_fsh);
            end
            r_fph <= r_fph + 1'b1;
        end
    end

    assign w_five_hit = (r_f <= FIVE_LIMIT);

    // Reduced denominator and the factor counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c5 <= '0;
            r_c2 <= '0;
        end else if (i_cmd.wb && (i_cmd.div_op == OP_RED)) begin
            r_red <= w_quo;
        end else if (i_cmd.five_wb && w_five_hit) begin
            r_red <= r_f;
            r_c5  <= r_c5 + 1'b1;
        end else if (i_cmd.shift2) begin
            r_red <= r_red >> 1;
            r_c2  <= r_c2 + 1'b1;
        end
    end

    // Larger count, saturated to the width of the length field.
    assign w_cmax    = (r_c5 > r_c2) ? r_c5 : r_c2;
    assign w_len_ext = LW'(w_cmax);
    assign w_len     = (w_len_ext > LW'(LEN_MAX)) ? LEN_WIDTH'(LEN_MAX)
                                                   : w_len_ext[LEN_WIDTH-1:0];

    // Output register; a zero denominator reports zero for both fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_den == '0) begin
                r_out_den <= '0;
                r_out_len <= '0;
            end else begin
                r_out_den <= r_red;
                r_out_len <= w_len;
            end
        end
    end

    assign o_stripped_denominator = r_out_den;
    assign o_preperiod_length     = r_out_len;

    // Status toward the controller.
    assign o_status.den_zero  = (r_den == '0);
    assign o_status.x_zero    = (r_x == '0);
    assign o_status.y_zero    = (r_y == '0);
    assign o_status.x_gt_y    = (r_x > r_y);
    assign o_status.div_last  = w_last;
    assign o_status.five_last = (r_fph == PH_NEGATE);
    assign o_status.five_hit  = w_five_hit;
    assign o_status.red_even  = ~r_red[0];

`ifndef SYNTH
    a_red_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wb && (i_cmd.div_op == OP_RED)) |=> (r_red != '0))
        else $error("reduced denominator is zero");

    a_shift_even : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift2 |-> (!r_red[0] && (r_red != '0)))
        else $error("factor two stripped from an odd value");

    a_out_odd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && (r_den != '0)) |-> r_red[0])
        else $error("stripped denominator still even at output");
`endif

endmodule

/* hw/rtl/dpl_ctrl.sv */
// Controller state machine: sequences Euclid, reduction, factor stripping and output.
// Depends on dpl_pkg; drives the datapath through t_cmd and reads t_status.
module dpl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dpl_pkg::t_status i_status,
    output dpl_pkg::t_cmd    o_cmd
);
    import dpl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_GCD  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_WB   = 8'b0000_1000,
        S_FIVE = 8'b0001_0000,
        S_FMUL = 8'b0010_0000,
        S_FCHK = 8'b0100_0000,
        S_TWO  = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    t_div_op r_op, n_op;
    logic    r_out_valid, n_out_valid;
    logic    r_done, n_done;

    logic    w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_done      = r_done;
        o_cmd       = '0;
        o_cmd.div_op = r_op;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                // A finished result waits here until the output slot frees up.
                if (r_done) begin
                    if (w_slot_free) begin
                        o_cmd.out_load = 1'b1;
                        n_done         = 1'b0;
                    end
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (i_status.den_zero) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    if (i_status.x_zero || i_status.y_zero) begin
                        n_op = OP_RED;
                    end else if (i_status.x_gt_y) begin
                        n_op = OP_MODX;
                    end else begin
                        n_op = OP_MODY;
                    end
                    o_cmd.div_op    = n_op;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                case (r_op)
                    OP_MODX: n_state = S_GCD;
                    OP_MODY: n_state = S_GCD;
                    OP_RED:  n_state = S_FIVE;
                    default: n_state = S_GCD;
                endcase
            end
            S_FIVE: begin
                o_cmd.five_start = 1'b1;
                n_state          = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.five_step = 1'b1;
                if (i_status.five_last) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                // Keep stripping fives while the exact quotient is in range.
                o_cmd.five_wb = 1'b1;
                n_state       = i_status.five_hit ? S_FIVE : S_TWO;
            end
            S_TWO: begin
                if (i_status.red_even) begin
                    o_cmd.shift2 = 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set on load, cleared when the request is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_MODX;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_accept_to_gcd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_GCD))
        else $error("accepted request did not start the gcd loop");

    a_load_sets_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("output load did not raise valid");

    a_div_runs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && !i_status.div_last) |=> (r_state == S_DIV))
        else $error("division left before its last bit");

    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_done && (r_state == S_IDLE)))
        else $error("ready raised while a request is in flight");
`endif

endmodule

/* hw/rtl/decimal_preperiod_length.sv */
// Top level of the decimal pre-period length block.
// Depends on dpl_pkg; instantiates dpl_ctrl and dpl_datapath.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready   | i_numerator, i_denominator
//  output   | o_out_valid / i_out_ready | o_stripped_denominator, o_preperiod_length
//
// Every divider pass runs start, W bit steps and writeback, W = VALUE_WIDTH.
// Every factor-five test runs load, six multiply steps, then compare and writeback.
// One request runs the Euclid modulo passes, the reduction pass, one factor-five test per
// factor of five plus a failing one, and one shift per factor of two; the divider dominates.
// One request is in work at a time; the next is taken once its result is in the output register.
// Synchronous active-low reset clears the controller; in the datapath only the divider's bit counter is reset.
// A stalled output holds its request and keeps the block from loading the next result.
module decimal_preperiod_length #(
    parameter int VALUE_WIDTH = dpl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [VALUE_WIDTH-1:0]          i_numerator,
    input  logic [VALUE_WIDTH-1:0]          i_denominator,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [VALUE_WIDTH-1:0]          o_stripped_denominator,
    output logic [dpl_pkg::LEN_WIDTH-1:0]   o_preperiod_length
);
    import dpl_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencing.
    dpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and result storage.
    dpl_datapath #(
        .W (VALUE_WIDTH)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_status               (w_status),
        .i_numerator            (i_numerator),
        .i_denominator          (i_denominator),
        .o_stripped_denominator (o_stripped_denominator),
        .o_preperiod_length     (o_preperiod_length)
    );

endmodule

/* sim/tb_decimal_preperiod_length.sv */
// Testbench for decimal_preperiod_length: random and directed fraction requests with
// a scoreboard class that predicts the stripped denominator and pre-period length.
// Depends on dpl_pkg and the decimal_preperiod_length RTL.
module tb_decimal_preperiod_length;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = dpl_pkg::VALUE_WIDTH_DEF;
    localparam int LW = dpl_pkg::LEN_WIDTH;
    localparam longint unsigned MAXV = (64'd1 << VW) - 64'd1;
    localparam int RANDOM_REQUESTS = 580;
    localparam int QUIET_TAIL = 60;
    localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

    typedef struct packed {
        logic [VW-1:0] stripped_den;
        logic [LW-1:0] preperiod;
    } t_fraction_result;

    // Holds the expected result of every accepted request and compares outputs in order.
    class t_preperiod_scoreboard;
        t_fraction_result expected_q[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Reduce by the gcd, then strip and count the factors five and two.
        function t_fraction_result reduce_and_strip(logic [VW-1:0] num, logic [VW-1:0] den);
            longint unsigned  x;
            longint unsigned  y;
            longint unsigned  g;
            longint unsigned  red;
            int unsigned      fives;
            int unsigned      twos;
            int unsigned      len;
            t_fraction_result res;
            res = '0;
            if (den == '0) begin
                return res;
            end
            x = num;
            y = den;
            while (x != 0 && y != 0) begin
                if (x > y) begin
                    x = x % y;
                end else begin
                    y = y % x;
                end
            end
            g = (x > y) ? x : y;
            red = den / g;
            fives = 0;
            twos = 0;
            while (red % 5 == 0) begin
                red = red / 5;
                fives++;
            end
            while (red % 2 == 0) begin
                red = red / 2;
                twos++;
            end
            len = (fives > twos) ? fives : twos;
            if (len > dpl_pkg::LEN_MAX) begin
                len = dpl_pkg::LEN_MAX;
            end
            res.stripped_den = red[VW-1:0];
            res.preperiod = len[LW-1:0];
            return res;
        endfunction

        function void note_fraction(logic [VW-1:0] num, logic [VW-1:0] den);
            expected_q.push_back(reduce_and_strip(num, den));
        endfunction

        function void check_result(logic [VW-1:0] stripped_den, logic [LW-1:0] preperiod);
            t_fraction_result exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: stripped_den=%0d preperiod=%0d",
                             stripped_den, preperiod);
                end
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.stripped_den !== stripped_den || exp_res.preperiod !== preperiod) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch: stripped_den exp %0d got %0d, %s %0d got %0d",
                             exp_res.stripped_den, stripped_den, "preperiod exp",
                             exp_res.preperiod, preperiod);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (expected_q.size() == 0);
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    logic [VW-1:0] i_numerator;
    logic [VW-1:0] i_denominator;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [VW-1:0] o_stripped_denominator;
    logic [LW-1:0] o_preperiod_length;

    t_preperiod_scoreboard sb;
    bit                    idle_on;
    int unsigned           stall_left = 0;
    longint unsigned       cycle_count = 0;

    decimal_preperiod_length u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_numerator            (i_numerator),
        .i_denominator          (i_denominator),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_stripped_denominator (o_stripped_denominator),
        .o_preperiod_length     (o_preperiod_length)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Note every accepted request and check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_fraction(i_numerator, i_denominator);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_stripped_denominator, o_preperiod_length);
            end
        end
    end

    // Output side backpressure: random stall bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_fraction(input logic [VW-1:0] num, input logic [VW-1:0] den);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_numerator <= num;
        i_denominator <= den;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) begin
                break;
            end
        end
    endtask

    task automatic pause_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Hold off new requests until every result has come back.
    task automatic drain_results();
        pause_sender(1);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random fraction: mostly denominators built from powers of two and five
    // times an odd-ish cofactor, with numerators that share some of those factors.
    task automatic make_fraction(output logic [VW-1:0] num, output logic [VW-1:0] den);
        longint unsigned v;
        longint unsigned smooth;
        longint unsigned hi;
        int unsigned     a;
        int unsigned     b;
        if ($urandom_range(0, 9) <= 2) begin
            v = $urandom & MAXV;
            if (v == 0) begin
                v = 1;
            end
            den = VW'(v);
            num = VW'($urandom & MAXV);
            return;
        end
        v = 1;
        a = $urandom_range(0, 30);
        b = $urandom_range(0, 13);
        for (int unsigned i = 0; i < a; i++) begin
            if (v * 2 <= MAXV) begin
                v = v * 2;
            end
        end
        for (int unsigned i = 0; i < b; i++) begin
            if (v * 5 <= MAXV) begin
                v = v * 5;
            end
        end
        smooth = v;
        hi = MAXV / v;
        if ($urandom_range(0, 1) == 0 && hi > 64) begin
            hi = 64;
        end
        v = v * $urandom_range(1, 32'(hi));
        den = VW'(v);
        case ($urandom_range(0, 5))
            0: begin
                num = '0;
            end
            1, 2: begin
                num = VW'($urandom & MAXV);
            end
            3: begin
                num = VW'((smooth >> $urandom_range(0, 4))
                          * $urandom_range(0, 32'(MAXV / smooth)));
            end
            4: begin
                num = VW'(v * $urandom_range(0, 32'(MAXV / v)));
            end
            default: begin
                num = VW'($urandom_range(1, 100));
            end
        endcase
    endtask

    // Main sequence: reset, directed corners, random requests, drain and verdict.
    initial begin
        logic [VW-1:0] num;
        logic [VW-1:0] den;
        sb = new();
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_numerator = '0;
        i_denominator = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: zero numerator, full-scale operands, pure powers of two
        // and five, worst-case Euclid pair, equal and alternating bit patterns.
        send_fraction('0, VW'(1));
        send_fraction('0, VW'(MAXV));
        send_fraction(VW'(MAXV), VW'(MAXV));
        send_fraction(VW'(MAXV), VW'(1));
        send_fraction(VW'(1), VW'(MAXV));
        send_fraction(VW'(1), VW'(1));
        send_fraction(VW'(1), VW'(1073741824));
        send_fraction(VW'(536870912), VW'(1073741824));
        send_fraction(VW'(1), VW'(1220703125));
        send_fraction(VW'(3), VW'(1220703125));
        send_fraction(VW'(1), VW'(1000000000));
        send_fraction(VW'(7), VW'(1000000000));
        send_fraction(VW'(12345), VW'(1953125000));
        send_fraction(VW'(1836311903), VW'(1134903170));
        send_fraction(VW'(1134903170), VW'(1836311903));
        send_fraction(VW'(1431655765), VW'(715827882));
        send_fraction(VW'(715827882), VW'(1431655765));
        send_fraction(VW'(6), VW'(4));
        send_fraction(VW'(10), VW'(25));
        send_fraction(VW'(77), VW'(77));
        drain_results();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // A calm stretch in the middle and no idling at the tail.
            idle_on = !((i >= 200 && i < 260) || i >= RANDOM_REQUESTS - QUIET_TAIL);
            if (i == RANDOM_REQUESTS / 2) begin
                drain_results();
            end
            if (idle_on && $urandom_range(0, 4) == 0) begin
                pause_sender($urandom_range(1, 17));
            end
            make_fraction(num, den);
            send_fraction(num, den);
        end
        pause_sender(1);

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (sb.clean()) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dpl_pkg.sv
hw/rtl/dpl_divider.sv
hw/rtl/dpl_datapath.sv
hw/rtl/dpl_ctrl.sv
hw/rtl/decimal_preperiod_length.sv
sim/tb_decimal_preperiod_length.sv
